>>> design/mcws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcws_pkg
// shared codes, register map and result record of the watchdog supervisor
// ----------------------------------------------------------------------------
package mcws_pkg;

  // request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_TOUCH  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CHECK  = 2'd3
  } req_type_e;

  // result codes carried by event_kind
  typedef enum logic [3:0] {
    EV_KILL      = 4'd0,
    EV_MULTIKILL = 4'd1,
    EV_MEGAMISS  = 4'd2,
    EV_MISS      = 4'd3,
    EV_DONE      = 4'd4,
    EV_ADD_OK    = 4'd5,
    EV_ADD_REJ   = 4'd6,
    EV_REM_OK    = 4'd7,
    EV_REM_NF    = 4'd8
  } event_kind_e;

  // configuration register map (word index)
  localparam int CFG_AW    = 5;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEGAMISS_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIKILL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIKILL_PCT   = 3'd4;

  localparam int LIMIT_W = 32;
  localparam int PCT_W   = 7;

  localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST     = 32'd200;
  localparam logic [LIMIT_W-1:0] MEGAMISS_LIMIT_RST = 32'd1000;

  // minimum stuck count for multikill and the percent scale
  localparam int MK_MIN   = 2;
  localparam int PCT_FULL = 100;

  // one result item
  typedef struct packed {
    event_kind_e  kind;
    logic [2:0]   chan;
    logic [31:0]  checkin;
    logic [7:0]   mask;
    logic [3:0]   cnt;
    logic         last;
  } result_t;

  function automatic result_t mk_result(event_kind_e kind, logic [2:0] chan,
                                        logic [31:0] checkin, logic [7:0] mask,
                                        logic [3:0] cnt, logic last);
    result_t r;
    r.kind    = kind;
    r.chan    = chan;
    r.checkin = checkin;
    r.mask    = mask;
    r.cnt     = cnt;
    r.last    = last;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/multi_channel_watchdog_supervisor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_watchdog_supervisor_top
// watchdog supervisor over CHANNELS channels with miss, megamiss, kill and
// multikill detection; check-in and alert times live in one ram
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i/in_ready_o): one item is a touch, add, remove or
//   check request. ready is high while the sequencer is idle, also while a
//   result still waits in the output register.
//   output channel (out_valid_o/out_ready_i): one result item per event; the
//   final result of a request has last_o set. a touch gives no result.
//   apb port: five limit registers at byte addresses 0,4,8,12,16.
// sequence
//   touch: done in the idle state. add and remove: result registered from
//   S_ONE. check: the scan skips inactive channels, reads and rewrites
//   touched ones, and reads, compares and sends kill and multikill results
//   for the rest; then a megamiss pass and a miss pass over the hit flags,
//   then done. each channel visit of the scan makes a single ram read.
// reset and stall
//   reset clears all channels, alert flags and the limits to their defaults;
//   the ram needs no clearing since entries are written by add before use.
//   a stalled receiver holds the sequencer at its next result; nothing drops.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_supervisor_top #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          req_type_i,
  input  wire logic [2:0]                          channel_i,
  input  wire logic [31:0]                         now_time_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [3:0]                               event_kind_o,
  output logic [2:0]                               event_channel_o,
  output logic [31:0]                              last_checkin_time_o,
  output logic [7:0]                               stuck_mask_o,
  output logic [3:0]                               stuck_count_o,
  output logic                                     last_o,
  // apb configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mcws_pkg::CFG_AW-1:0]         paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int IW  = $clog2(CHANNELS);
  localparam int CW  = $clog2(CHANNELS + 1);
  localparam int PW  = mcws_pkg::PCT_W + CW;
  localparam int MW  = (CHANNELS > 8) ? CHANNELS : 8;
  localparam int SCW = (CW > 4) ? CW : 4;
  localparam int DW  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int RW  = 2 * TIME_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ONE, S_RD, S_SUB, S_CMP, S_KILL, S_MK,
    S_GRD, S_GEM, S_MRD, S_MEM, S_DONE
  } state_e;

  // sequencer and flags
  state_e                state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [CHANNELS-1:0]   active_q, active_d;
  logic [CHANNELS-1:0]   touched_q, touched_d;
  logic [CHANNELS-1:0]   miss_al_q, miss_al_d;
  logic [CHANNELS-1:0]   mega_al_q, mega_al_d;
  logic [CHANNELS-1:0]   av_q, av_d;
  logic [CHANNELS-1:0]   miss_hit_q, miss_hit_d;
  logic [CHANNELS-1:0]   mega_hit_q, mega_hit_d;
  logic [MW-1:0]         stuck_mask_q, stuck_mask_d;
  logic [CW-1:0]         stuck_cnt_q, stuck_cnt_d;
  logic [PW-1:0]         need_prod_q, need_prod_d;
  logic                  kill_pend_q, kill_pend_d;
  logic                  mk_pend_q, mk_pend_d;
  // per item payload
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [TIME_BITS-1:0]  delta_q, delta_d;
  logic [2:0]            ch_q, ch_d;
  mcws_pkg::event_kind_e one_kind_q, one_kind_d;
  // output register
  logic                  out_valid_q, out_valid_d;
  mcws_pkg::result_t     res_q, res_d;
  // limits
  logic [31:0]           miss_lim_q, miss_lim_d;
  logic [31:0]           mega_lim_q, mega_lim_d;
  logic [31:0]           kill_lim_q, kill_lim_d;
  logic [31:0]           mk_lim_q, mk_lim_d;
  logic [6:0]            pct_q, pct_d;

  // ram port
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [RW-1:0]         ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0]  rd_checkin, rd_alert;

  logic                  accept, slot_free, ch_ok, cfg_we, stuck;
  logic                  miss_h, mega_h;
  logic [IW-1:0]         in_idx;
  logic [TIME_BITS-1:0]  now_in;
  logic [CW-1:0]         cnt_new;
  logic [SCW-1:0]        cnt_ext;
  logic [mcws_pkg::CFG_IDX_W-1:0] cfg_idx;

  // entry layout: {alert_time, checkin_time}
  mcws_ram #(
    .WIDTH (RW),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_checkin = ram_rdata[TIME_BITS-1:0];
  assign rd_alert   = ram_rdata[RW-1:TIME_BITS];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign ch_ok      = (32'(channel_i) < CHANNELS);
  assign in_idx     = ch_ok ? IW'(channel_i) : '0;
  assign now_in     = TIME_BITS'(now_time_i);
  assign cnt_new    = stuck_cnt_q + 1'b1;
  assign cnt_ext    = SCW'(stuck_cnt_q);

  // apb access
  assign pready  = 1'b1;
  assign cfg_idx = paddr[mcws_pkg::CFG_AW-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      mcws_pkg::REG_MISS_LIMIT:      prdata = miss_lim_q;
      mcws_pkg::REG_MEGAMISS_LIMIT:  prdata = mega_lim_q;
      mcws_pkg::REG_KILL_LIMIT:      prdata = kill_lim_q;
      mcws_pkg::REG_MULTIKILL_LIMIT: prdata = mk_lim_q;
      mcws_pkg::REG_MULTIKILL_PCT:   prdata = 32'(pct_q);
      default:                       prdata = '0;
    endcase
  end

  // threshold compares of the current channel
  always_comb begin
    miss_h = (DW'(delta_q) > DW'(miss_lim_q)) && !miss_al_q[idx_q];
    mega_h = (DW'(delta_q) > DW'(mega_lim_q)) && !mega_al_q[idx_q];
    stuck  = (mk_lim_q != '0) && (DW'(delta_q) > DW'(mk_lim_q));
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    active_d     = active_q;
    touched_d    = touched_q;
    miss_al_d    = miss_al_q;
    mega_al_d    = mega_al_q;
    av_d         = av_q;
    miss_hit_d   = miss_hit_q;
    mega_hit_d   = mega_hit_q;
    stuck_mask_d = stuck_mask_q;
    stuck_cnt_d  = stuck_cnt_q;
    need_prod_d  = need_prod_q;
    kill_pend_d  = kill_pend_q;
    mk_pend_d    = mk_pend_q;
    now_d        = now_q;
    last_d       = last_q;
    delta_d      = delta_q;
    ch_d         = ch_q;
    one_kind_d   = one_kind_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = {rd_alert, now_q};
    ram_re       = 1'b0;
    ram_raddr    = idx_q;

    miss_lim_d = miss_lim_q;
    mega_lim_d = mega_lim_q;
    kill_lim_d = kill_lim_q;
    mk_lim_d   = mk_lim_q;
    pct_d      = pct_q;
    if (cfg_we) begin
      case (cfg_idx)
        mcws_pkg::REG_MISS_LIMIT:      miss_lim_d = pwdata;
        mcws_pkg::REG_MEGAMISS_LIMIT:  mega_lim_d = pwdata;
        mcws_pkg::REG_KILL_LIMIT:      kill_lim_d = pwdata;
        mcws_pkg::REG_MULTIKILL_LIMIT: mk_lim_d   = pwdata;
        mcws_pkg::REG_MULTIKILL_PCT:   pct_d      = pwdata[6:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          now_d = now_in;
          ch_d  = channel_i;
          case (mcws_pkg::req_type_e'(req_type_i))
            mcws_pkg::REQ_TOUCH: begin
              if (ch_ok && active_q[in_idx]) begin
                touched_d[in_idx] = 1'b1;
              end
            end
            mcws_pkg::REQ_ADD: begin
              state_d = S_ONE;
              if (!ch_ok || active_q[in_idx]) begin
                one_kind_d = mcws_pkg::EV_ADD_REJ;
              end else begin
                one_kind_d        = mcws_pkg::EV_ADD_OK;
                active_d[in_idx]  = 1'b1;
                touched_d[in_idx] = 1'b1;
                miss_al_d[in_idx] = 1'b0;
                mega_al_d[in_idx] = 1'b0;
                av_d[in_idx]      = 1'b0;
                ram_we            = 1'b1;
                ram_waddr         = in_idx;
                ram_wdata         = {{TIME_BITS{1'b0}}, now_in};
              end
            end
            mcws_pkg::REQ_REMOVE: begin
              state_d = S_ONE;
              if (!ch_ok || !active_q[in_idx]) begin
                one_kind_d = mcws_pkg::EV_REM_NF;
              end else begin
                one_kind_d        = mcws_pkg::EV_REM_OK;
                active_d[in_idx]  = 1'b0;
                touched_d[in_idx] = 1'b0;
                ram_re            = 1'b1;
                ram_raddr         = in_idx;
              end
            end
            mcws_pkg::REQ_CHECK: begin
              state_d      = S_RD;
              idx_d        = '0;
              miss_hit_d   = '0;
              mega_hit_d   = '0;
              stuck_mask_d = '0;
              stuck_cnt_d  = '0;
              // ceil(pct * active / 100) <= n  <=>  pct * active <= 100 * n
              need_prod_d  = PW'(pct_q) * PW'(CW'($countones(active_q)));
            end
            default: ;
          endcase
        end
      end

      S_ONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          case (one_kind_q)
            mcws_pkg::EV_ADD_OK:
              res_d = mcws_pkg::mk_result(one_kind_q, ch_q, 32'(now_q), '0, '0, 1'b1);
            mcws_pkg::EV_REM_OK:
              res_d = mcws_pkg::mk_result(one_kind_q, ch_q, 32'(rd_checkin), '0, '0,
                                          1'b1);
            default:
              res_d = mcws_pkg::mk_result(one_kind_q, ch_q, '0, '0, '0, 1'b1);
          endcase
        end
      end

      // scan: read the entry of an active channel
      S_RD: begin
        if (active_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = S_SUB;
        end else if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_GRD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_SUB: begin
        last_d = rd_checkin;
        if (touched_q[idx_q]) begin
          // touched channel checks in at now and is skipped
          touched_d[idx_q] = 1'b0;
          ram_we           = 1'b1;
          ram_wdata        = {rd_alert, now_q};
          if (idx_q == LAST_IDX) begin
            idx_d   = '0;
            state_d = S_GRD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end else begin
          delta_d = now_q - rd_checkin;
          // check-in moved since the last alert: new stall episode
          if (av_q[idx_q] && (rd_alert != rd_checkin)) begin
            miss_al_d[idx_q] = 1'b0;
            mega_al_d[idx_q] = 1'b0;
          end
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        if (miss_h) begin
          miss_al_d[idx_q]  = 1'b1;
          miss_hit_d[idx_q] = 1'b1;
        end
        if (mega_h) begin
          mega_al_d[idx_q]  = 1'b1;
          mega_hit_d[idx_q] = 1'b1;
        end
        if (miss_h || mega_h) begin
          av_d[idx_q] = 1'b1;
          ram_we      = 1'b1;
          ram_wdata   = {last_q, last_q};
        end
        kill_pend_d = (kill_lim_q != '0) && (DW'(delta_q) > DW'(kill_lim_q));
        mk_pend_d   = 1'b0;
        if (stuck) begin
          stuck_mask_d = stuck_mask_q | (MW'(1) << idx_q);
          stuck_cnt_d  = cnt_new;
          mk_pend_d    = (cnt_new >= CW'(mcws_pkg::MK_MIN))
                      && ((PW'(cnt_new) * PW'(mcws_pkg::PCT_FULL)) >= need_prod_q);
        end
        state_d = S_KILL;
      end

      S_KILL: begin
        if (!kill_pend_q) begin
          state_d = S_MK;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          res_d       = mcws_pkg::mk_result(mcws_pkg::EV_KILL, 3'(idx_q), 32'(last_q),
                                            '0, '0, 1'b0);
          kill_pend_d = 1'b0;
          state_d     = S_MK;
        end
      end

      S_MK: begin
        if (!mk_pend_q || slot_free) begin
          if (mk_pend_q) begin
            out_valid_d = 1'b1;
            res_d       = mcws_pkg::mk_result(mcws_pkg::EV_MULTIKILL, 3'(idx_q),
                                              32'(last_q), stuck_mask_q[7:0],
                                              cnt_ext[3:0], 1'b0);
            mk_pend_d   = 1'b0;
          end
          if (idx_q == LAST_IDX) begin
            idx_d   = '0;
            state_d = S_GRD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end

      // megamiss reports in index order
      S_GRD: begin
        if (mega_hit_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = S_GEM;
        end else if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_MRD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_GEM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          res_d       = mcws_pkg::mk_result(mcws_pkg::EV_MEGAMISS, 3'(idx_q),
                                            32'(rd_checkin), '0, '0, 1'b0);
          if (idx_q == LAST_IDX) begin
            idx_d   = '0;
            state_d = S_MRD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_GRD;
          end
        end
      end

      // miss reports in index order
      S_MRD: begin
        if (miss_hit_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = S_MEM;
        end else if (idx_q == LAST_IDX) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_MEM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          res_d       = mcws_pkg::mk_result(mcws_pkg::EV_MISS, 3'(idx_q),
                                            32'(rd_checkin), '0, '0, 1'b0);
          if (idx_q == LAST_IDX) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_MRD;
          end
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          res_d       = mcws_pkg::mk_result(mcws_pkg::EV_DONE, '0, '0, '0, '0, 1'b1);
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      active_q     <= '0;
      touched_q    <= '0;
      miss_al_q    <= '0;
      mega_al_q    <= '0;
      av_q         <= '0;
      miss_hit_q   <= '0;
      mega_hit_q   <= '0;
      stuck_mask_q <= '0;
      stuck_cnt_q  <= '0;
      need_prod_q  <= '0;
      kill_pend_q  <= 1'b0;
      mk_pend_q    <= 1'b0;
      now_q        <= '0;
      last_q       <= '0;
      delta_q      <= '0;
      ch_q         <= '0;
      one_kind_q   <= mcws_pkg::EV_DONE;
      out_valid_q  <= 1'b0;
      res_q        <= '0;
      miss_lim_q   <= mcws_pkg::MISS_LIMIT_RST;
      mega_lim_q   <= mcws_pkg::MEGAMISS_LIMIT_RST;
      kill_lim_q   <= '0;
      mk_lim_q     <= '0;
      pct_q        <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      active_q     <= active_d;
      touched_q    <= touched_d;
      miss_al_q    <= miss_al_d;
      mega_al_q    <= mega_al_d;
      av_q         <= av_d;
      miss_hit_q   <= miss_hit_d;
      mega_hit_q   <= mega_hit_d;
      stuck_mask_q <= stuck_mask_d;
      stuck_cnt_q  <= stuck_cnt_d;
      need_prod_q  <= need_prod_d;
      kill_pend_q  <= kill_pend_d;
      mk_pend_q    <= mk_pend_d;
      now_q        <= now_d;
      last_q       <= last_d;
      delta_q      <= delta_d;
      ch_q         <= ch_d;
      one_kind_q   <= one_kind_d;
      out_valid_q  <= out_valid_d;
      res_q        <= res_d;
      miss_lim_q   <= miss_lim_d;
      mega_lim_q   <= mega_lim_d;
      kill_lim_q   <= kill_lim_d;
      mk_lim_q     <= mk_lim_d;
      pct_q        <= pct_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign event_kind_o        = res_q.kind;
  assign event_channel_o     = res_q.chan;
  assign last_checkin_time_o = res_q.checkin;
  assign stuck_mask_o        = res_q.mask;
  assign stuck_count_o       = res_q.cnt;
  assign last_o              = res_q.last;

  // stuck bookkeeping stays consistent
  a_stuck_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(stuck_mask_q) == int'(stuck_cnt_q))
    else $error("stuck count differs from stuck mask");

  // only active channels carry a pending touch
  a_touch_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (touched_q & ~active_q) == '0)
    else $error("touched flag on inactive channel");

  // an alerted channel always has a recorded alert time
  a_alert_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((miss_al_q | mega_al_q) & ~av_q) == '0)
    else $error("alert flag without alert time");

  // only multikill results carry stuck data
  a_mk_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != mcws_pkg::EV_MULTIKILL)
      |-> (stuck_mask_o == '0) && (stuck_count_o == '0))
    else $error("stuck data on non-multikill result");

  // last marks exactly the closing results of a request
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == ((event_kind_o == mcws_pkg::EV_DONE)
                             || (event_kind_o == mcws_pkg::EV_ADD_OK)
                             || (event_kind_o == mcws_pkg::EV_ADD_REJ)
                             || (event_kind_o == mcws_pkg::EV_REM_OK)
                             || (event_kind_o == mcws_pkg::EV_REM_NF))))
    else $error("last flag does not match result kind");

endmodule
`default_nettype wire

>>> design/mcws_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcws_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mcws_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
